// ===== hdl/tbt_pkg.sv =====
package tbt_pkg;

    // Field widths of the transfers.
    localparam int COORD_WIDTH      = 24;
    localparam int WEIGHT_FRAC_BITS = 16;
    localparam int WEIGHT_WIDTH     = 32;
    localparam int THRESH_WIDTH     = 63;

    // Internal widths. All arithmetic before the division is exact.
    localparam int DIFF_WIDTH = COORD_WIDTH + 1;
    localparam int PROD_WIDTH = 2 * DIFF_WIDTH;
    localparam int DOT_WIDTH  = PROD_WIDTH + 2;
    localparam int LO_WIDTH   = DOT_WIDTH / 2;
    localparam int HI_WIDTH   = DOT_WIDTH - LO_WIDTH;
    localparam int GRAM_WIDTH = 2 * DOT_WIDTH + 1;
    localparam int NUM_WIDTH  = GRAM_WIDTH + WEIGHT_FRAC_BITS;
    localparam int REM_WIDTH  = NUM_WIDTH + WEIGHT_WIDTH;
    localparam int SUM_WIDTH  = WEIGHT_WIDTH + 2;

    // Ten fixed stages plus one stage per quotient bit.
    localparam int PIPE_DEPTH = 10 + WEIGHT_WIDTH;

    localparam logic [WEIGHT_WIDTH-1:0] WEIGHT_MAX = {1'b0, {(WEIGHT_WIDTH-1){1'b1}}};
    localparam logic [WEIGHT_WIDTH-1:0] WEIGHT_MIN = {1'b1, {(WEIGHT_WIDTH-1){1'b0}}};
    localparam logic [THRESH_WIDTH-1:0] THRESH_RESET = THRESH_WIDTH'(1);

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] query_x;
        logic signed [COORD_WIDTH-1:0] query_y;
        logic signed [COORD_WIDTH-1:0] query_z;
        logic signed [COORD_WIDTH-1:0] vertex_a_x;
        logic signed [COORD_WIDTH-1:0] vertex_a_y;
        logic signed [COORD_WIDTH-1:0] vertex_a_z;
        logic signed [COORD_WIDTH-1:0] vertex_b_x;
        logic signed [COORD_WIDTH-1:0] vertex_b_y;
        logic signed [COORD_WIDTH-1:0] vertex_b_z;
        logic signed [COORD_WIDTH-1:0] vertex_c_x;
        logic signed [COORD_WIDTH-1:0] vertex_c_y;
        logic signed [COORD_WIDTH-1:0] vertex_c_z;
    } t_query;

    typedef struct packed {
        logic signed [WEIGHT_WIDTH-1:0] weight_u;
        logic signed [WEIGHT_WIDTH-1:0] weight_v;
        logic signed [WEIGHT_WIDTH-1:0] weight_w;
        logic                           degenerate;
        logic                           inside_res;
    } t_result;

endpackage

// ===== hdl/triangle_barycentric_test.sv =====
// Channel   Direction  Handshake            Payload
// input     in         i_valid / o_stall    i_data  (t_query, twelve coordinates)
// output    out        o_valid / i_stall    o_data  (t_result, weights and flags)
// config    in         i_cfg_we             i_cfg_wdata (degenerate threshold)
//
// One query is taken per cycle while o_stall is low. The pipeline depth is
// set by the restoring divider, which resolves one quotient bit per stage
// for both weights in parallel.
// Reset (synchronous, active low) clears all valid bits and sets the
// threshold to 1. When the output is stalled, a skid register takes one more
// result and o_stall rises only once that register is full.
module triangle_barycentric_test (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  tbt_pkg::t_query               i_data,
    output logic                          o_valid,
    input  logic                          i_stall,
    output tbt_pkg::t_result              o_data,
    input  logic                          i_cfg_we,
    input  logic [tbt_pkg::THRESH_WIDTH-1:0] i_cfg_wdata
);
    import tbt_pkg::*;

    localparam int LAST = PIPE_DEPTH - 1;

    // Pipeline advance. The whole pipeline moves unless the skid register
    // is occupied; the skid register is only filled while the output waits.
    logic en;

    logic [THRESH_WIDTH-1:0] r_thr;
    logic [PIPE_DEPTH-1:0]   r_vld;

    // Stage 1: edge vectors e0 = B - A, e1 = C - A and offset q = P - A.
    logic signed [COORD_WIDTH-1:0] c_p [3];
    logic signed [COORD_WIDTH-1:0] c_a [3];
    logic signed [COORD_WIDTH-1:0] c_b [3];
    logic signed [COORD_WIDTH-1:0] c_c [3];
    logic signed [DIFF_WIDTH-1:0]  r_e0 [3];
    logic signed [DIFF_WIDTH-1:0]  r_e1 [3];
    logic signed [DIFF_WIDTH-1:0]  r_q  [3];

    // Stage 2: the fifteen coordinate products behind the five dot products.
    // Row order: d00, d01, d11, d20, d21.
    logic signed [DIFF_WIDTH-1:0] op_x [5][3];
    logic signed [DIFF_WIDTH-1:0] op_y [5][3];
    logic signed [PROD_WIDTH-1:0] r_prod [5][3];

    // Stage 3: dot products.
    logic signed [DOT_WIDTH-1:0] r_dot [5];

    // Stage 4: partial products of the six wide multiplications.
    // den = m0 - m1, nv = m2 - m3, nw = m4 - m5.
    logic signed [DOT_WIDTH-1:0]       mul_a [6];
    logic signed [DOT_WIDTH-1:0]       mul_b [6];
    logic signed [2*HI_WIDTH-1:0]      r_pp_hh [6];
    logic signed [HI_WIDTH+LO_WIDTH:0] r_pp_hl [6];
    logic signed [HI_WIDTH+LO_WIDTH:0] r_pp_lh [6];
    logic        [2*LO_WIDTH-1:0]      r_pp_ll [6];

    // Stage 5: full products. Stage 6: denominator and numerators.
    logic signed [GRAM_WIDTH-1:0] r_gram [6];
    logic signed [GRAM_WIDTH-1:0] r_den;
    logic signed [GRAM_WIDTH-1:0] r_nv;
    logic signed [GRAM_WIDTH-1:0] r_nw;

    // Stage 7: magnitudes, signs and the degenerate test.
    logic [GRAM_WIDTH-1:0] n_dm;
    logic [GRAM_WIDTH-1:0] n_nvm;
    logic [GRAM_WIDTH-1:0] n_nwm;
    logic [GRAM_WIDTH-1:0] r_dm;
    logic [NUM_WIDTH-1:0]  r_nm_v;
    logic [NUM_WIDTH-1:0]  r_nm_w;
    logic                  r_sg_v;
    logic                  r_sg_w;
    logic                  r_deg;

    // Stage 8 feeds entry 0 of the divider; each later stage resolves one
    // quotient bit, most significant first. A quotient of 2^32 or more is
    // caught up front as overflow, so 32 bits of remainder steps suffice.
    logic [REM_WIDTH-1:0]    r_rem_v [WEIGHT_WIDTH+1];
    logic [REM_WIDTH-1:0]    r_rem_w [WEIGHT_WIDTH+1];
    logic [WEIGHT_WIDTH-1:0] r_quo_v [WEIGHT_WIDTH+1];
    logic [WEIGHT_WIDTH-1:0] r_quo_w [WEIGHT_WIDTH+1];
    logic [GRAM_WIDTH-1:0]   r_ddm   [WEIGHT_WIDTH+1];
    logic                    r_dsg_v [WEIGHT_WIDTH+1];
    logic                    r_dsg_w [WEIGHT_WIDTH+1];
    logic                    r_dov_v [WEIGHT_WIDTH+1];
    logic                    r_dov_w [WEIGHT_WIDTH+1];
    logic                    r_ddeg  [WEIGHT_WIDTH+1];
    logic [REM_WIDTH-1:0]    n_rem_v [WEIGHT_WIDTH];
    logic [REM_WIDTH-1:0]    n_rem_w [WEIGHT_WIDTH];
    logic [WEIGHT_WIDTH-1:0] n_quo_v [WEIGHT_WIDTH];
    logic [WEIGHT_WIDTH-1:0] n_quo_w [WEIGHT_WIDTH];

    // Saturated signed weights, then the final result with u.
    logic signed [WEIGHT_WIDTH-1:0] r_wv;
    logic signed [WEIGHT_WIDTH-1:0] r_ww;
    logic                           r_sdeg;
    logic signed [SUM_WIDTH-1:0]    n_usum;
    logic signed [WEIGHT_WIDTH-1:0] n_u;
    t_result                        r_res;

    // Output register and skid register.
    t_result r_out;
    t_result r_skid;
    logic    r_out_vld;
    logic    r_skid_vld;
    logic    take;

    function automatic logic signed [PROD_WIDTH-1:0] mul_coord(
        input logic signed [DIFF_WIDTH-1:0] x,
        input logic signed [DIFF_WIDTH-1:0] y
    );
        return PROD_WIDTH'(x) * PROD_WIDTH'(y);
    endfunction

    // Turns the quotient magnitude into a signed weight clamped to 32 bits.
    function automatic logic [WEIGHT_WIDTH-1:0] sat_weight(
        input logic [WEIGHT_WIDTH-1:0] mag,
        input logic                    ov,
        input logic                    neg
    );
        logic [WEIGHT_WIDTH-1:0] res;
        if (ov) begin
            res = neg ? WEIGHT_MIN : WEIGHT_MAX;
        end else if (neg) begin
            res = (mag[WEIGHT_WIDTH-1] && (mag[WEIGHT_WIDTH-2:0] != '0)) ? WEIGHT_MIN : -mag;
        end else begin
            res = mag[WEIGHT_WIDTH-1] ? WEIGHT_MAX : mag;
        end
        return res;
    endfunction

    assign en      = !r_skid_vld;
    assign o_stall = r_skid_vld;
    assign o_valid = r_out_vld;
    assign o_data  = r_out;
    assign take    = r_out_vld && !i_stall;

    always_comb begin
        c_p[0] = i_data.query_x;    c_p[1] = i_data.query_y;    c_p[2] = i_data.query_z;
        c_a[0] = i_data.vertex_a_x; c_a[1] = i_data.vertex_a_y; c_a[2] = i_data.vertex_a_z;
        c_b[0] = i_data.vertex_b_x; c_b[1] = i_data.vertex_b_y; c_b[2] = i_data.vertex_b_z;
        c_c[0] = i_data.vertex_c_x; c_c[1] = i_data.vertex_c_y; c_c[2] = i_data.vertex_c_z;
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            op_x[0][k] = r_e0[k]; op_y[0][k] = r_e0[k];
            op_x[1][k] = r_e0[k]; op_y[1][k] = r_e1[k];
            op_x[2][k] = r_e1[k]; op_y[2][k] = r_e1[k];
            op_x[3][k] = r_q[k];  op_y[3][k] = r_e0[k];
            op_x[4][k] = r_q[k];  op_y[4][k] = r_e1[k];
        end
        mul_a[0] = r_dot[0]; mul_b[0] = r_dot[2];
        mul_a[1] = r_dot[1]; mul_b[1] = r_dot[1];
        mul_a[2] = r_dot[2]; mul_b[2] = r_dot[3];
        mul_a[3] = r_dot[1]; mul_b[3] = r_dot[4];
        mul_a[4] = r_dot[0]; mul_b[4] = r_dot[4];
        mul_a[5] = r_dot[1]; mul_b[5] = r_dot[3];
    end

    always_comb begin
        n_dm  = r_den[GRAM_WIDTH-1] ? -r_den : r_den;
        n_nvm = r_nv[GRAM_WIDTH-1]  ? -r_nv  : r_nv;
        n_nwm = r_nw[GRAM_WIDTH-1]  ? -r_nw  : r_nw;
    end

    // One restoring step per stage: subtract the shifted divisor when it fits.
    always_comb begin
        for (int k = 0; k < WEIGHT_WIDTH; k++) begin
            n_rem_v[k] = r_rem_v[k];
            n_rem_w[k] = r_rem_w[k];
            n_quo_v[k] = r_quo_v[k];
            n_quo_w[k] = r_quo_w[k];
            if (r_rem_v[k] >= (REM_WIDTH'(r_ddm[k]) << (WEIGHT_WIDTH - 1 - k))) begin
                n_rem_v[k] = r_rem_v[k] - (REM_WIDTH'(r_ddm[k]) << (WEIGHT_WIDTH - 1 - k));
                n_quo_v[k][WEIGHT_WIDTH-1-k] = 1'b1;
            end
            if (r_rem_w[k] >= (REM_WIDTH'(r_ddm[k]) << (WEIGHT_WIDTH - 1 - k))) begin
                n_rem_w[k] = r_rem_w[k] - (REM_WIDTH'(r_ddm[k]) << (WEIGHT_WIDTH - 1 - k));
                n_quo_w[k][WEIGHT_WIDTH-1-k] = 1'b1;
            end
        end
    end

    // u = 1 - v - w from the clamped weights, clamped again.
    always_comb begin
        n_usum = (SUM_WIDTH'(1) << WEIGHT_FRAC_BITS) - SUM_WIDTH'(r_wv) - SUM_WIDTH'(r_ww);
        if (!n_usum[SUM_WIDTH-1] && (n_usum[SUM_WIDTH-2:WEIGHT_WIDTH-1] != '0)) begin
            n_u = WEIGHT_MAX;
        end else if (n_usum[SUM_WIDTH-1] && (n_usum[SUM_WIDTH-2:WEIGHT_WIDTH-1] != '1)) begin
            n_u = WEIGHT_MIN;
        end else begin
            n_u = n_usum[WEIGHT_WIDTH-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= THRESH_RESET;
        end else if (i_cfg_we) begin
            r_thr <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[PIPE_DEPTH-2:0], i_valid};
        end
    end

    // Datapath registers; they carry no reset because the valid bits qualify them.
    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                r_e0[k] <= DIFF_WIDTH'(c_b[k]) - DIFF_WIDTH'(c_a[k]);
                r_e1[k] <= DIFF_WIDTH'(c_c[k]) - DIFF_WIDTH'(c_a[k]);
                r_q[k]  <= DIFF_WIDTH'(c_p[k]) - DIFF_WIDTH'(c_a[k]);
            end
            for (int j = 0; j < 5; j++) begin
                for (int k = 0; k < 3; k++) begin
                    r_prod[j][k] <= mul_coord(op_x[j][k], op_y[j][k]);
                end
                r_dot[j] <= DOT_WIDTH'(r_prod[j][0]) + DOT_WIDTH'(r_prod[j][1])
                          + DOT_WIDTH'(r_prod[j][2]);
            end
            for (int m = 0; m < 6; m++) begin
                r_pp_hh[m] <= $signed(mul_a[m][DOT_WIDTH-1:LO_WIDTH])
                            * $signed(mul_b[m][DOT_WIDTH-1:LO_WIDTH]);
                r_pp_hl[m] <= $signed(mul_a[m][DOT_WIDTH-1:LO_WIDTH])
                            * $signed({1'b0, mul_b[m][LO_WIDTH-1:0]});
                r_pp_lh[m] <= $signed({1'b0, mul_a[m][LO_WIDTH-1:0]})
                            * $signed(mul_b[m][DOT_WIDTH-1:LO_WIDTH]);
                r_pp_ll[m] <= mul_a[m][LO_WIDTH-1:0] * mul_b[m][LO_WIDTH-1:0];
                r_gram[m]  <= (GRAM_WIDTH'(r_pp_hh[m]) << (2 * LO_WIDTH))
                            + (GRAM_WIDTH'(r_pp_hl[m]) << LO_WIDTH)
                            + (GRAM_WIDTH'(r_pp_lh[m]) << LO_WIDTH)
                            + GRAM_WIDTH'(r_pp_ll[m]);
            end
            r_den <= r_gram[0] - r_gram[1];
            r_nv  <= r_gram[2] - r_gram[3];
            r_nw  <= r_gram[4] - r_gram[5];

            r_dm   <= n_dm;
            r_nm_v <= NUM_WIDTH'(n_nvm) << WEIGHT_FRAC_BITS;
            r_nm_w <= NUM_WIDTH'(n_nwm) << WEIGHT_FRAC_BITS;
            r_sg_v <= r_nv[GRAM_WIDTH-1] ^ r_den[GRAM_WIDTH-1];
            r_sg_w <= r_nw[GRAM_WIDTH-1] ^ r_den[GRAM_WIDTH-1];
            r_deg  <= (r_den == '0) || (n_dm < GRAM_WIDTH'(r_thr));

            r_rem_v[0] <= REM_WIDTH'(r_nm_v);
            r_rem_w[0] <= REM_WIDTH'(r_nm_w);
            r_quo_v[0] <= '0;
            r_quo_w[0] <= '0;
            r_ddm[0]   <= r_dm;
            r_dsg_v[0] <= r_sg_v;
            r_dsg_w[0] <= r_sg_w;
            r_dov_v[0] <= REM_WIDTH'(r_nm_v) >= (REM_WIDTH'(r_dm) << WEIGHT_WIDTH);
            r_dov_w[0] <= REM_WIDTH'(r_nm_w) >= (REM_WIDTH'(r_dm) << WEIGHT_WIDTH);
            r_ddeg[0]  <= r_deg;
            for (int k = 0; k < WEIGHT_WIDTH; k++) begin
                r_rem_v[k+1] <= n_rem_v[k];
                r_rem_w[k+1] <= n_rem_w[k];
                r_quo_v[k+1] <= n_quo_v[k];
                r_quo_w[k+1] <= n_quo_w[k];
                r_ddm[k+1]   <= r_ddm[k];
                r_dsg_v[k+1] <= r_dsg_v[k];
                r_dsg_w[k+1] <= r_dsg_w[k];
                r_dov_v[k+1] <= r_dov_v[k];
                r_dov_w[k+1] <= r_dov_w[k];
                r_ddeg[k+1]  <= r_ddeg[k];
            end

            // A degenerate triangle forces every weight to zero.
            r_wv   <= r_ddeg[WEIGHT_WIDTH] ? '0 : $signed(sat_weight(r_quo_v[WEIGHT_WIDTH],
                                            r_dov_v[WEIGHT_WIDTH], r_dsg_v[WEIGHT_WIDTH]));
            r_ww   <= r_ddeg[WEIGHT_WIDTH] ? '0 : $signed(sat_weight(r_quo_w[WEIGHT_WIDTH],
                                            r_dov_w[WEIGHT_WIDTH], r_dsg_w[WEIGHT_WIDTH]));
            r_sdeg <= r_ddeg[WEIGHT_WIDTH];

            r_res.weight_u   <= r_sdeg ? '0 : n_u;
            r_res.weight_v   <= r_wv;
            r_res.weight_w   <= r_ww;
            r_res.degenerate <= r_sdeg;
            r_res.inside_res <= !r_sdeg && !n_u[WEIGHT_WIDTH-1]
                             && !r_wv[WEIGHT_WIDTH-1] && !r_ww[WEIGHT_WIDTH-1];
        end
    end

    // Output side. A finished result goes to the output register when it is
    // free or being taken this cycle, otherwise into the skid register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (r_skid_vld) begin
            if (take) begin
                r_out      <= r_skid;
                r_skid_vld <= 1'b0;
            end
        end else if (r_vld[LAST]) begin
            if (!r_out_vld || take) begin
                r_out     <= r_res;
                r_out_vld <= 1'b1;
            end else begin
                r_skid     <= r_res;
                r_skid_vld <= 1'b1;
            end
        end else if (take) begin
            r_out_vld <= 1'b0;
        end
    end

endmodule

// ===== hdl/tbt_checker.sv =====
module tbt_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             o_stall,
    input logic                             o_valid,
    input logic                             i_stall,
    input tbt_pkg::t_result                 o_data
);
    import tbt_pkg::*;

    logic signed [SUM_WIDTH-1:0]    usum;
    logic signed [WEIGHT_WIDTH-1:0] uexp;

    always_comb begin
        usum = (SUM_WIDTH'(1) << WEIGHT_FRAC_BITS) - SUM_WIDTH'(o_data.weight_v)
             - SUM_WIDTH'(o_data.weight_w);
        if (!usum[SUM_WIDTH-1] && (usum[SUM_WIDTH-2:WEIGHT_WIDTH-1] != '0)) begin
            uexp = WEIGHT_MAX;
        end else if (usum[SUM_WIDTH-1] && (usum[SUM_WIDTH-2:WEIGHT_WIDTH-1] != '1)) begin
            uexp = WEIGHT_MIN;
        end else begin
            uexp = usum[WEIGHT_WIDTH-1:0];
        end
    end

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_data))
        else $error("stalled result changed");

    a_degen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.degenerate |-> o_data.weight_u == '0 && o_data.weight_v == '0
            && o_data.weight_w == '0 && !o_data.inside_res)
        else $error("degenerate result carries weights");

    a_inside: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.inside_res |-> !o_data.degenerate && !o_data.weight_u[WEIGHT_WIDTH-1]
            && !o_data.weight_v[WEIGHT_WIDTH-1] && !o_data.weight_w[WEIGHT_WIDTH-1])
        else $error("inside flag with a negative weight");

    a_usum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_data.degenerate |-> o_data.weight_u == uexp)
        else $error("weight u does not complete v and w");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !o_stall)
        else $error("handshake active after reset");

endmodule

bind triangle_barycentric_test tbt_checker u_tbt_checker (.*);

// ===== test/triangle_barycentric_test_test.sv =====
module triangle_barycentric_test_test;
    import tbt_pkg::*;

    // Holds the predicted weights of every query that has been taken in and
    // compares each result that leaves the block against the oldest one.
    class weight_scoreboard;
        t_result pending[$];
        logic [THRESH_WIDTH-1:0] threshold;
        int errors;
        int checked;
        int degenerate_seen;
        int inside_seen;

        function new();
            threshold = THRESH_RESET;
            errors = 0;
            checked = 0;
            degenerate_seen = 0;
            inside_seen = 0;
        endfunction

        // Exact integer barycentric weights, truncating division, saturated.
        function t_result weigh(t_query q);
            logic signed [255:0] p[3], a[3], b[3], c[3];
            logic signed [255:0] e0[3], e1[3], d[3];
            logic signed [255:0] d00, d01, d11, d20, d21, den, mag, nv, nw, v, w, u;
            t_result r;
            p = '{$signed(q.query_x), $signed(q.query_y), $signed(q.query_z)};
            a = '{$signed(q.vertex_a_x), $signed(q.vertex_a_y), $signed(q.vertex_a_z)};
            b = '{$signed(q.vertex_b_x), $signed(q.vertex_b_y), $signed(q.vertex_b_z)};
            c = '{$signed(q.vertex_c_x), $signed(q.vertex_c_y), $signed(q.vertex_c_z)};
            for (int k = 0; k < 3; k++) begin
                e0[k] = b[k] - a[k];
                e1[k] = c[k] - a[k];
                d[k]  = p[k] - a[k];
            end
            d00 = e0[0] * e0[0] + e0[1] * e0[1] + e0[2] * e0[2];
            d01 = e0[0] * e1[0] + e0[1] * e1[1] + e0[2] * e1[2];
            d11 = e1[0] * e1[0] + e1[1] * e1[1] + e1[2] * e1[2];
            d20 = d[0] * e0[0] + d[1] * e0[1] + d[2] * e0[2];
            d21 = d[0] * e1[0] + d[1] * e1[1] + d[2] * e1[2];
            den = d00 * d11 - d01 * d01;
            mag = (den < 0) ? -den : den;
            r = '0;
            // A zero denominator always counts as degenerate, even with a zero threshold.
            if (den == 0 || mag < $signed({193'b0, threshold})) begin
                r.degenerate = 1'b1;
                return r;
            end
            nv = (d11 * d20 - d01 * d21) <<< WEIGHT_FRAC_BITS;
            nw = (d00 * d21 - d01 * d20) <<< WEIGHT_FRAC_BITS;
            v = nv / den;
            w = nw / den;
            if (v > 256'sd2147483647) v = 256'sd2147483647;
            if (v < -256'sd2147483648) v = -256'sd2147483648;
            if (w > 256'sd2147483647) w = 256'sd2147483647;
            if (w < -256'sd2147483648) w = -256'sd2147483648;
            // The first weight is formed from the already clamped ones.
            u = (256'sd1 <<< WEIGHT_FRAC_BITS) - v - w;
            if (u > 256'sd2147483647) u = 256'sd2147483647;
            if (u < -256'sd2147483648) u = -256'sd2147483648;
            r.weight_u = u[31:0];
            r.weight_v = v[31:0];
            r.weight_w = w[31:0];
            r.inside_res = (u >= 0 && v >= 0 && w >= 0);
            return r;
        endfunction

        function void note_query(t_query q);
            pending.push_back(weigh(q));
        endfunction

        function void check_result(t_result got);
            t_result want;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result u=%0d v=%0d w=%0d deg=%0b in=%0b", $time,
                         got.weight_u, got.weight_v, got.weight_w, got.degenerate,
                         got.inside_res);
                errors++;
                return;
            end
            want = pending.pop_front();
            checked++;
            if (want.degenerate) degenerate_seen++;
            if (want.inside_res) inside_seen++;
            if (got !== want) begin
                $display("%0t: mismatch expected u=%0d v=%0d w=%0d deg=%0b in=%0b", $time,
                         want.weight_u, want.weight_v, want.weight_w, want.degenerate,
                         want.inside_res);
                $display("%0t:          actual   u=%0d v=%0d w=%0d deg=%0b in=%0b", $time,
                         got.weight_u, got.weight_v, got.weight_w, got.degenerate,
                         got.inside_res);
                errors++;
            end
        endfunction
    endclass

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_valid = 1'b0;
    logic                    o_stall;
    t_query                  i_data = '0;
    logic                    o_valid;
    logic                    i_stall = 1'b0;
    t_result                 o_data;
    logic                    i_cfg_we = 1'b0;
    logic [THRESH_WIDTH-1:0] i_cfg_wdata = '0;

    weight_scoreboard weights = new();

    // While set, neither side inserts idle cycles.
    logic steady = 1'b0;
    int   sent = 0;

    always #1 i_clk = ~i_clk;

    triangle_barycentric_test u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_data      (i_data),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_data      (o_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    // Outside the steady stretch the receiver stalls at random, with a chance of 31 in 100.
    always @(posedge i_clk) begin
        i_stall <= !steady && ($urandom_range(99) < 31);
    end

    // Values sampled right after the edge are the ones the block saw at that edge.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            weights.check_result(o_data);
        end
    end

    // Offers one query and holds it until the transfer completes.
    task automatic send_query(t_query q);
        while (!steady && $urandom_range(99) < 31) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= q;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        weights.note_query(q);
        sent++;
    endtask

    // Lowers valid, waits for every outstanding result and lets the pipe drain.
    task automatic drain();
        i_valid <= 1'b0;
        while (weights.pending.size() != 0) @(posedge i_clk);
        repeat (PIPE_DEPTH + 8) @(posedge i_clk);
    endtask

    // The threshold only changes while the block holds no query.
    task automatic set_threshold(logic [THRESH_WIDTH-1:0] value);
        drain();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        weights.threshold = value;
    endtask

    function automatic logic signed [COORD_WIDTH-1:0] coord(int span);
        if (span <= 0) return COORD_WIDTH'($urandom());
        return COORD_WIDTH'($urandom_range(2 * span) - span);
    endfunction

    function automatic t_query make_query(int px, int py, int pz, int ax, int ay, int az,
                                          int bx, int by, int bz, int cx, int cy, int cz);
        t_query q;
        q.query_x = COORD_WIDTH'(px);    q.query_y = COORD_WIDTH'(py);
        q.query_z = COORD_WIDTH'(pz);
        q.vertex_a_x = COORD_WIDTH'(ax); q.vertex_a_y = COORD_WIDTH'(ay);
        q.vertex_a_z = COORD_WIDTH'(az);
        q.vertex_b_x = COORD_WIDTH'(bx); q.vertex_b_y = COORD_WIDTH'(by);
        q.vertex_b_z = COORD_WIDTH'(bz);
        q.vertex_c_x = COORD_WIDTH'(cx); q.vertex_c_y = COORD_WIDTH'(cy);
        q.vertex_c_z = COORD_WIDTH'(cz);
        return q;
    endfunction

    // Random triangle: one third fully random coordinates, one third tiny triangles
    // (degenerate and saturating cases), the rest a query placed on or near the
    // triangle's plane so that inside hits are common.
    function automatic t_query random_query();
        t_query q;
        int kind, span, fa, fb;
        kind = $urandom_range(2);
        span = (kind == 1) ? $urandom_range(4) : 0;
        if (kind == 2) span = 1 << $urandom_range(4, 21);
        q = make_query(coord(span), coord(span), coord(span), coord(span), coord(span),
                       coord(span), coord(span), coord(span), coord(span), coord(span),
                       coord(span), coord(span));
        if (kind == 2) begin
            fa = $urandom_range(20);
            fb = $urandom_range(20 - fa);
            fa -= 2;
            fb -= 2;
            q.query_x = COORD_WIDTH'(q.vertex_a_x + ((q.vertex_b_x - q.vertex_a_x) * fa
                        + (q.vertex_c_x - q.vertex_a_x) * fb) / 16);
            q.query_y = COORD_WIDTH'(q.vertex_a_y + ((q.vertex_b_y - q.vertex_a_y) * fa
                        + (q.vertex_c_y - q.vertex_a_y) * fb) / 16);
            q.query_z = COORD_WIDTH'(q.vertex_a_z + ((q.vertex_b_z - q.vertex_a_z) * fa
                        + (q.vertex_c_z - q.vertex_a_z) * fb) / 16);
        end
        return q;
    endfunction

    initial begin
        localparam int MX = 8388607;
        localparam int MN = -8388608;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed queries under the reset threshold of one.
        // Centroid of a plain right triangle: inside, weights near a third.
        send_query(make_query(1365, 1365, 0, 0, 0, 0, 4096, 0, 0, 0, 4096, 0));
        // Queries on two of the vertices give exact unit weights.
        send_query(make_query(4096, 0, 0, 0, 0, 0, 4096, 0, 0, 0, 4096, 0));
        send_query(make_query(0, 0, 0, 0, 0, 0, 4096, 0, 0, 0, 4096, 0));
        // Outside point, negative weights.
        send_query(make_query(-4096, -4096, 77, 0, 0, 0, 4096, 0, 0, 0, 4096, 0));
        // Three equal vertices and a collinear triangle: zero denominator.
        send_query(make_query(5, 6, 7, 9, 9, 9, 9, 9, 9, 9, 9, 9));
        send_query(make_query(1, 2, 3, 0, 0, 0, 100, 100, 100, 200, 200, 200));
        // Unit-LSB triangle with a far query: both weights saturate.
        send_query(make_query(MX, MX, 0, 0, 0, 0, 1, 0, 0, 0, 1, 0));
        send_query(make_query(MN, MN, 0, 0, 0, 0, 1, 0, 0, 0, 1, 0));
        send_query(make_query(MX, MN, MX, 0, 0, 0, 1, 0, 0, 0, 1, 0));
        // Coordinates at both ends of their range.
        send_query(make_query(MX, MX, MX, MN, MN, MN, MX, MN, MN, MN, MX, MN));
        send_query(make_query(MN, MN, MN, MX, MX, MX, MN, MX, MX, MX, MN, MX));
        send_query(make_query(0, 0, 0, MX, MN, MX, MN, MX, MN, MX, MX, MN));
        send_query(make_query(-1, -1, -1, -1, -1, -1, -1, -1, -1, -1, -1, -1));

        // A zero threshold still flags the zero denominator.
        set_threshold('0);
        send_query(make_query(5, 6, 7, 9, 9, 9, 9, 9, 9, 9, 9, 9));
        send_query(make_query(1, 0, 0, 0, 0, 0, 1, 0, 0, 0, 1, 0));
        // The largest threshold flags the small triangle but not the full-range one.
        set_threshold({THRESH_WIDTH{1'b1}});
        send_query(make_query(1365, 1365, 0, 0, 0, 0, 4096, 0, 0, 0, 4096, 0));
        send_query(make_query(MX, MX, MX, MN, MN, MN, MX, MN, MN, MN, MX, MN));
        // Threshold right at the denominator of a unit-LSB triangle, then just above.
        set_threshold(THRESH_WIDTH'(1));
        send_query(make_query(0, 0, 0, 0, 0, 0, 1, 0, 0, 0, 1, 0));
        set_threshold(THRESH_WIDTH'(2));
        send_query(make_query(0, 0, 0, 0, 0, 0, 1, 0, 0, 0, 1, 0));

        // Random phases, each with its own threshold write; the second runs steady.
        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0: set_threshold(THRESH_RESET);
                1: set_threshold('0);
                2: set_threshold(THRESH_WIDTH'($urandom_range(16)));
                3: set_threshold(THRESH_WIDTH'({$urandom(), $urandom()} >> $urandom_range(62)));
                4: set_threshold(THRESH_WIDTH'(64'd1) << $urandom_range(40, 62));
                default: set_threshold({THRESH_WIDTH{1'b1}});
            endcase
            steady = (phase == 1);
            for (int n = 0; n < 175; n++) begin
                send_query(random_query());
                // Let the sender hold off once mid-phase until all results are back.
                if (phase == 3 && n == 80) drain();
            end
            steady = 1'b0;
        end

        drain();
        if (weights.pending.size() != 0) begin
            $display("%0t: %0d expected results never arrived", $time, weights.pending.size());
            weights.errors++;
        end
        $display("Sent %0d queries across ten threshold writes; %0d results checked.",
                 sent, weights.checked);
        $display("Among them %0d degenerate and %0d inside the triangle.",
                 weights.degenerate_seen, weights.inside_seen);
        if (weights.errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    initial begin
        #400000;
        $display("%0t: timeout", $time);
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== files.f =====
hdl/tbt_pkg.sv
hdl/triangle_barycentric_test.sv
hdl/tbt_checker.sv
test/triangle_barycentric_test_test.sv
